### src/kl_pkg.sv
// shared types, constants and keyword table for the keyword lexer
package kl_pkg;

  localparam int POSITION_BITS = 16;
  localparam int MAX_IDENT_LEN = 255;
  localparam int LEN_BITS      = $clog2(MAX_IDENT_LEN + 1);

  localparam int CHAR_BITS     = 8;
  localparam int KIND_BITS     = 5;
  localparam int START_BITS    = 16;
  localparam int LENGTH_BITS   = 8;

  localparam int KW_COUNT      = 11;
  localparam int KW_MAXLEN     = 6;
  localparam int PFX_IDX_BITS  = $clog2(KW_MAXLEN);

  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS      = $clog2(FIFO_DEPTH + 1);

  localparam logic [KIND_BITS-1:0] KIND_IS      = 5'd5;
  localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd11;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd12;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd13;
  localparam logic [KIND_BITS-1:0] KIND_COMMA   = 5'd14;
  localparam logic [KIND_BITS-1:0] KIND_EOF     = 5'd15;
  localparam logic [KIND_BITS-1:0] KIND_INVALID = 5'd16;

  localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h0a;
  localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_BITS-1:0] CH_COMMA  = 8'h2c;
  localparam logic [CHAR_BITS-1:0] CH_EQUALS = 8'h3d;

  // make put get remove redo is in if not and or
  localparam logic [CHAR_BITS-1:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
    '{8'h6d, 8'h61, 8'h6b, 8'h65, 8'h00, 8'h00},
    '{8'h70, 8'h75, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h67, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h6d, 8'h6f, 8'h76, 8'h65},
    '{8'h72, 8'h65, 8'h64, 8'h6f, 8'h00, 8'h00},
    '{8'h69, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6e, 8'h6f, 8'h74, 8'h00, 8'h00, 8'h00},
    '{8'h61, 8'h6e, 8'h64, 8'h00, 8'h00, 8'h00},
    '{8'h6f, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int KW_LEN [KW_COUNT] = '{4, 3, 3, 6, 4, 2, 2, 2, 3, 3, 2};

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [START_BITS-1:0]  start;
    logic [LENGTH_BITS-1:0] length;
    logic                   last;
  } tok_t;

  // up to two tokens from one character; a lone token sits in first
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       first;
    tok_t       second;
  } tok_pair_t;

endpackage

### src/kl_ifs.sv
// valid/ready channel interfaces for characters and tokens
interface kl_ch_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface kl_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] ident_start;
  logic [7:0]  ident_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output ident_start,
                  output ident_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input ident_start,
                input ident_length, input last_of_run, output ready);
endinterface

### src/kl_kw_match.sv
// keyword compare of the open word prefix against the keyword table
module kl_kw_match (
  input  logic [kl_pkg::CHAR_BITS-1:0] prefix_i [kl_pkg::KW_MAXLEN],
  input  logic [kl_pkg::LEN_BITS-1:0]  len_i,
  input  logic                         overflow_i,
  output logic                         hit_o,
  output logic [kl_pkg::KIND_BITS-1:0] kind_o
);
  import kl_pkg::*;

  always_comb begin
    logic eq;
    hit_o  = 1'b0;
    kind_o = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      eq = !overflow_i && (32'(len_i) == KW_LEN[k]);
      // only entries below the word length are looked at
      for (int j = 0; j < KW_MAXLEN; j++) begin
        if (j < KW_LEN[k] && prefix_i[j] != KW_TEXT[k][j]) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        hit_o  = 1'b1;
        kind_o = KIND_BITS'(k);
      end
    end
  end

endmodule

### src/kl_scan.sv
// lexer state and one-character step producing up to two tokens
module kl_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [kl_pkg::CHAR_BITS-1:0] ch_i,
  output kl_pkg::tok_pair_t            push_o
);
  import kl_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
  localparam logic [LEN_BITS-1:0]      LEN_MAX   = LEN_BITS'(MAX_IDENT_LEN);
  localparam logic [LEN_BITS-1:0]      LEN_PFX   = LEN_BITS'(KW_MAXLEN);
  localparam logic [START_BITS-1:0]    START_SAT = '1;
  localparam logic [LENGTH_BITS-1:0]   LENGTH_SAT = '1;

  logic [POSITION_BITS-1:0] pos_q, pos_d, pos_adv;
  logic                     in_ident_q, in_ident_d;
  logic [POSITION_BITS-1:0] wstart_q, wstart_d;
  logic [LEN_BITS-1:0]      wlen_q, wlen_d;
  logic                     ovf_q, ovf_d;
  logic [CHAR_BITS-1:0]     prefix_q [KW_MAXLEN];
  logic [CHAR_BITS-1:0]     prefix_d [KW_MAXLEN];

  logic                 kw_hit;
  logic [KIND_BITS-1:0] kw_kind;
  logic                 is_letter, is_word;
  tok_t                 word_tok, single_tok;
  logic                 have_single;

  kl_kw_match u_kw_match (
    .prefix_i   (prefix_q),
    .len_i      (wlen_q),
    .overflow_i (ovf_q),
    .hit_o      (kw_hit),
    .kind_o     (kw_kind)
  );

  assign is_letter = ch_i inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  assign is_word   = is_letter || (ch_i inside {[8'h30:8'h39]});
  assign pos_adv   = (pos_q == POS_MAX) ? pos_q : pos_q + POSITION_BITS'(1);

  // token for the word that is closing
  always_comb begin
    word_tok      = '0;
    word_tok.last = 1'b0;
    if (kw_hit) begin
      word_tok.kind = kw_kind;
    end else begin
      word_tok.kind = KIND_IDENT;
      if (32'(wstart_q) > 32'(START_SAT)) begin
        word_tok.start = START_SAT;
      end else begin
        word_tok.start = START_BITS'(wstart_q);
      end
      if (32'(wlen_q) > 32'(LENGTH_SAT)) begin
        word_tok.length = LENGTH_SAT;
      end else begin
        word_tok.length = LENGTH_BITS'(wlen_q);
      end
    end
  end

  always_comb begin
    pos_d       = pos_q;
    in_ident_d  = in_ident_q;
    wstart_d    = wstart_q;
    wlen_d      = wlen_q;
    ovf_d       = ovf_q;
    prefix_d    = prefix_q;
    push_o      = '0;
    single_tok  = '0;
    have_single = 1'b0;

    if (fire_i) begin
      if (in_ident_q && is_word) begin
        if (wlen_q < LEN_MAX) begin
          if (wlen_q < LEN_PFX) begin
            prefix_d[wlen_q[PFX_IDX_BITS-1:0]] = ch_i;
          end
          wlen_d = wlen_q + LEN_BITS'(1);
        end else begin
          ovf_d = 1'b1;
        end
        pos_d = pos_adv;
      end else begin
        if (in_ident_q) begin
          push_o.first = word_tok;
          push_o.cnt   = 2'd1;
          in_ident_d   = 1'b0;
        end

        if (ch_i inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
          pos_d = pos_adv;
        end else if (is_letter) begin
          in_ident_d  = 1'b1;
          wstart_d    = pos_q;
          wlen_d      = LEN_BITS'(1);
          ovf_d       = 1'b0;
          prefix_d[0] = ch_i;
          pos_d       = pos_adv;
        end else if (ch_i == CH_NUL) begin
          have_single     = 1'b1;
          single_tok.kind = KIND_EOF;
          pos_d           = '0;
          in_ident_d      = 1'b0;
          wstart_d        = '0;
          wlen_d          = '0;
          ovf_d           = 1'b0;
        end else begin
          have_single = 1'b1;
          case (ch_i)
            CH_EQUALS: single_tok.kind = KIND_IS;
            CH_LPAREN: single_tok.kind = KIND_LPAREN;
            CH_RPAREN: single_tok.kind = KIND_RPAREN;
            CH_COMMA:  single_tok.kind = KIND_COMMA;
            default:   single_tok.kind = KIND_INVALID;
          endcase
          pos_d = pos_adv;
        end

        single_tok.last = 1'b1;
        if (have_single) begin
          if (in_ident_q) begin
            push_o.second = single_tok;
            push_o.cnt    = 2'd2;
          end else begin
            push_o.first = single_tok;
            push_o.cnt   = 2'd1;
          end
        end else if (in_ident_q) begin
          push_o.first.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      in_ident_q <= 1'b0;
      wstart_q   <= '0;
      wlen_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      in_ident_q <= in_ident_d;
      wstart_q   <= wstart_d;
      wlen_q     <= wlen_d;
      ovf_q      <= ovf_d;
    end
  end

  // prefix entries are only read below the word length
  always_ff @(posedge clk_i) begin
    prefix_q <= prefix_d;
  end

`ifndef SYNTHESIS
  a_word_cont_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && in_ident_q && is_word |-> push_o.cnt == 2'd0)
    else $error("word character inside identifier produced a token");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && ch_i == CH_NUL |=> pos_q == '0 && !in_ident_q && wlen_q == '0)
    else $error("end of text did not clear the position and word state");

  a_pair_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !in_ident_q |-> push_o.cnt != 2'd2)
    else $error("two tokens without an open identifier");
`endif

endmodule

### src/kl_tok_fifo.sv
// small token queue: up to two beats in, one out per cycle when ready
module kl_tok_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kl_pkg::tok_pair_t push_i,
  output logic              room_o,
  kl_tok_if.source          out_o
);
  import kl_pkg::*;

  tok_t                mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_q, rd_q;
  logic [CNT_BITS-1:0] count_q;
  logic                pop;
  tok_t                head;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = count_q <= CNT_BITS'(FIFO_DEPTH - 2);
  assign head   = mem_q[rd_q];

  assign out_o.valid        = count_q != '0;
  assign out_o.token_kind   = head.kind;
  assign out_o.ident_start  = head.start;
  assign out_o.ident_length = head.length;
  assign out_o.last_of_run  = head.last;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + PTR_BITS'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PTR_BITS'(push_i.cnt);
      rd_q    <= rd_q + PTR_BITS'(pop);
      count_q <= count_q + CNT_BITS'(push_i.cnt) - CNT_BITS'(pop);
    end
  end

`ifndef SYNTHESIS
  a_pair_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt == 2'd2 |-> count_q <= CNT_BITS'(FIFO_DEPTH - 2))
    else $error("token pair pushed without room for two entries");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.cnt == 2'd0 |=> count_q == $past(count_q) - CNT_BITS'(1))
    else $error("queue count wrong after a pop");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 && !pop |=> out_o.valid)
    else $error("pushed token not offered at the output");
`endif

endmodule

### src/keyword_lexer.sv
// keyword lexer top level: input register, lexer step and token queue
//
// in_i carries one character byte per beat; a zero byte ends the text.
// out_o carries token beats: kind, identifier start and length, and
// last_of_run, set on the final token caused by one character.
// Whitespace gives no token, a letter opens an identifier, and a character
// that closes it gives the word token and then its own, if not whitespace.
// A character waits in the input register until the token queue has room.
// Throughput: one character per cycle while the queue has room; a character
// giving two tokens pushes both at once, and the one-beat-per-cycle output
// of the four-entry token queue sets the sustained rate at one token per
// cycle while the receiver is ready.
// The input register takes a new character while tokens wait in the queue.
// When the receiver stalls, the queue fills and then in_i.ready drops;
// no beat is lost or repeated.
// Reset clears the text position, the identifier state and the queue.
module keyword_lexer (
  input  logic     clk_i,
  input  logic     rst_ni,
  kl_ch_if.sink    in_i,
  kl_tok_if.source out_o
);
  import kl_pkg::*;

  logic                 in_valid_q;
  logic [CHAR_BITS-1:0] ch_q;
  logic                 room;
  logic                 fire;
  tok_pair_t            push;

  assign fire       = in_valid_q && room;
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q <= in_i.ch;
    end
  end

  kl_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .ch_i   (ch_q),
    .push_o (push)
  );

  kl_tok_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
